// ===== rtl/nmea_filt_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_filt_pkg
// Shared types, codes and constants of the NMEA sentence filter.
// ----------------------------------------------------------------------------
package nmea_filt_pkg;

    // Default size of one sentence buffer, in bytes.
    localparam int BUF_BYTES_DEF = 128;

    // Fixed widths of the transaction fields.
    localparam int CHARS_W = 24;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 7;
    localparam int LEN_W   = 8;

    // Register reset values: "$GP", "GGA", "GSA" and line feed.
    localparam logic [CHARS_W-1:0] HEADER_RESET = 24'h244750;
    localparam logic [CHARS_W-1:0] TYPE0_RESET  = 24'h474741;
    localparam logic [CHARS_W-1:0] TYPE1_RESET  = 24'h475341;
    localparam logic [BYTE_W-1:0]  END_RESET    = 8'h0A;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HEADER = 2'd0,
        CFG_TYPE0  = 2'd1,
        CFG_TYPE1  = 2'd2,
        CFG_END    = 2'd3
    } cfg_index_t;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Parser phases.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TYPE,
        PH_BODY
    } phase_t;

    // Configuration seen by the parser.
    typedef struct packed {
        logic [CHARS_W-1:0] header_chars;
        logic [CHARS_W-1:0] type0_chars;
        logic [CHARS_W-1:0] type1_chars;
        logic [BYTE_W-1:0]  end_char;
    } cfg_t;

    // Completion report of one byte.
    typedef struct packed {
        logic              done;
        logic              dtype;
        logic [LEN_W-1:0]  length;
    } done_t;

    // Character idx of a three-character word, first character in the top byte.
    // An index past the end selects the low byte.
    function automatic logic [BYTE_W-1:0] char_at(input logic [CHARS_W-1:0] word,
                                                  input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            2'd0:    c = word[23:16];
            2'd1:    c = word[15:8];
            default: c = word[7:0];
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/nmea_filt_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_filt_parser
// Header and type matcher, body write sequencing and buffer ready flags.
// ----------------------------------------------------------------------------
module nmea_filt_parser #(
    parameter int BUF_BYTES = nmea_filt_pkg::BUF_BYTES_DEF,
    parameter int WP_W      = $clog2(BUF_BYTES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nmea_filt_pkg::cfg_t          cfg,
    input  logic                         byte_en,
    input  logic [nmea_filt_pkg::BYTE_W-1:0] rx_byte,
    input  logic                         release_en,
    input  logic                         release_sel,
    output logic                         wr_en,
    output logic                         wr_sel,
    output logic [WP_W-1:0]              wr_pos,
    output logic [nmea_filt_pkg::BYTE_W-1:0] wr_data,
    output nmea_filt_pkg::done_t         done,
    output logic [1:0]                   ready_next
);
    import nmea_filt_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [1:0]      match_reg, match_next;
    logic [1:0]      cand_reg, cand_next;
    logic            type_reg, type_next;
    logic [WP_W-1:0] wp_reg, wp_next;
    logic [1:0]      ready_reg;

    logic            hdr_hit;
    logic [1:0]      cand_hit;
    logic            win_type;
    logic            is_end;
    logic            wp_full;

    assign hdr_hit     = (rx_byte == char_at(cfg.header_chars, match_reg));
    assign cand_hit[0] = cand_reg[0] && (rx_byte == char_at(cfg.type0_chars, match_reg));
    assign cand_hit[1] = cand_reg[1] && (rx_byte == char_at(cfg.type1_chars, match_reg));
    assign win_type    = !cand_hit[0];
    assign is_end      = (rx_byte == cfg.end_char);
    assign wp_full     = (wp_reg >= WP_W'(BUF_BYTES));

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        cand_next  = cand_reg;
        type_next  = type_reg;
        wp_next    = wp_reg;
        ready_next = ready_reg;
        if (release_en)
        begin
            ready_next[release_sel] = 1'b0;
        end
        if (byte_en)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_hit)
                    begin
                        if (match_reg == 2'd2)
                        begin
                            phase_next = PH_TYPE;
                            match_next = 2'd0;
                            cand_next  = 2'b11;
                        end
                        else
                        begin
                            match_next = match_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        match_next = 2'd0;
                    end
                end
                PH_TYPE:
                begin
                    cand_next = cand_hit;
                    if (cand_hit == 2'b00)
                    begin
                        phase_next = PH_HEADER;
                        match_next = 2'd0;
                    end
                    else if (match_reg == 2'd2)
                    begin
                        match_next = 2'd0;
                        if (!ready_reg[win_type])
                        begin
                            phase_next = PH_BODY;
                            type_next  = win_type;
                            wp_next    = '0;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    else
                    begin
                        match_next = match_reg + 2'd1;
                    end
                end
                PH_BODY:
                begin
                    if (is_end)
                    begin
                        ready_next[type_reg] = 1'b1;
                        phase_next = PH_HEADER;
                        match_next = 2'd0;
                    end
                    else if (!wp_full)
                    begin
                        wp_next = wp_reg + WP_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    match_next = 2'd0;
                end
            endcase
        end
    end

    // Outputs: buffer write and completion report.
    always_comb
    begin
        wr_en       = byte_en && (phase_reg == PH_BODY) && !is_end && !wp_full;
        wr_sel      = type_reg;
        wr_pos      = wp_reg;
        wr_data     = (wp_reg < WP_W'(BUF_BYTES - 1)) ? rx_byte : '0;
        done.done   = byte_en && (phase_reg == PH_BODY) && is_end;
        done.dtype  = done.done ? type_reg : 1'b0;
        done.length = done.done ? LEN_W'(wp_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            match_reg <= 2'd0;
            cand_reg  <= 2'b00;
            type_reg  <= 1'b0;
            wp_reg    <= '0;
            ready_reg <= 2'b00;
        end
        else
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            cand_reg  <= cand_next;
            type_reg  <= type_next;
            wp_reg    <= wp_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ===== rtl/nmea_filt_store.sv =====
// ----------------------------------------------------------------------------
// nmea_filt_store
// Sentence memory: two buffers, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nmea_filt_store #(
    parameter int BUF_BYTES = nmea_filt_pkg::BUF_BYTES_DEF,
    parameter int WP_W      = $clog2(BUF_BYTES + 1)
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic                             wr_sel,
    input  logic [WP_W-1:0]                  wr_pos,
    input  logic [nmea_filt_pkg::BYTE_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic                             rd_sel,
    input  logic [nmea_filt_pkg::POS_W-1:0]  rd_pos,
    output logic [nmea_filt_pkg::BYTE_W-1:0] rd_data
);
    import nmea_filt_pkg::*;

    localparam int DEPTH = 2 * BUF_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;

    // Buffer 1 starts right after buffer 0.
    assign wr_addr = (wr_sel ? AW'(BUF_BYTES) : AW'(0)) + AW'(wr_pos);
    assign rd_addr = (rd_sel ? AW'(BUF_BYTES) : AW'(0)) + AW'(rd_pos);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/nmea_sentence_filter_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_filter_unit
// NMEA 0183 sentence filter: matches a header and two sentence types in a
// received byte stream and stores matching sentence bodies for read-back.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -----------------------------------------
//  in       in_valid / in_stall    command, rx_byte, buffer_select,
//                                  read_position
//  out      out_valid / out_stall  read_data, ready_mask, sentence_done,
//                                  done_type, stored_length
//  cfg      cfg_write_en           cfg_index, cfg_data (no handshake wait)
//
// For every transaction the parser state, the buffer write and the memory
// read all happen at the accepting edge, and the result is loaded into the
// output register at that same edge. A new transaction is accepted in
// every cycle unless a held result is stalled; in_stall is only the output
// register being full and out_stall high. Reset clears the parser and the
// ready flags and returns the configuration to its reset values; the sentence memory is not cleared.
//
module nmea_sentence_filter_unit #(
    parameter int BUF_BYTES = nmea_filt_pkg::BUF_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write port.
    input  logic                              cfg_write_en,
    input  logic [1:0]                        cfg_index,
    input  logic [nmea_filt_pkg::CHARS_W-1:0] cfg_data,

    // Input channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        command,
    input  logic [nmea_filt_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                              buffer_select,
    input  logic [nmea_filt_pkg::POS_W-1:0]   read_position,

    // Output channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [nmea_filt_pkg::BYTE_W-1:0]  read_data,
    output logic [1:0]                        ready_mask,
    output logic                              sentence_done,
    output logic                              done_type,
    output logic [nmea_filt_pkg::LEN_W-1:0]   stored_length
);
    import nmea_filt_pkg::*;

    // Write position counts up to BUF_BYTES, so it needs one more code.
    localparam int WP_W = $clog2(BUF_BYTES + 1);

    cfg_t              cfg_reg;
    cmd_t              cmd;
    logic              accept;
    logic              byte_en;
    logic              release_en;
    logic              read_en;
    logic              read_hit;

    logic              wr_en;
    logic              wr_sel;
    logic [WP_W-1:0]   wr_pos;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] mem_q;
    done_t             done;
    logic [1:0]        ready_next;

    logic              out_valid_reg;
    logic              read_hit_reg;
    logic [1:0]        ready_mask_reg;
    done_t             done_reg;

    // The output register is the only buffer between the two sides, so the
    // input side waits only while a finished result is held back.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign cmd      = cmd_t'(command);

    assign byte_en    = accept && (cmd == CMD_BYTE);
    assign release_en = accept && (cmd == CMD_RELEASE);
    assign read_en    = accept && (cmd == CMD_READ);

    // Positions at or past the buffer size read as zero without a memory
    // access.
    assign read_hit = ({2'b00, read_position} < 9'(BUF_BYTES));

    // Configuration registers; writes must arrive only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_chars <= HEADER_RESET;
            cfg_reg.type0_chars  <= TYPE0_RESET;
            cfg_reg.type1_chars  <= TYPE1_RESET;
            cfg_reg.end_char     <= END_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEADER: cfg_reg.header_chars <= cfg_data;
                CFG_TYPE0:  cfg_reg.type0_chars  <= cfg_data;
                CFG_TYPE1:  cfg_reg.type1_chars  <= cfg_data;
                CFG_END:    cfg_reg.end_char     <= cfg_data[BYTE_W-1:0];
                default:    cfg_reg.end_char     <= cfg_reg.end_char;
            endcase
        end
    end

    // Header and type matching, body sequencing and ready flags.
    nmea_filt_parser #(
        .BUF_BYTES (BUF_BYTES),
        .WP_W      (WP_W)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .byte_en     (byte_en),
        .rx_byte     (rx_byte),
        .release_en  (release_en),
        .release_sel (buffer_select),
        .wr_en       (wr_en),
        .wr_sel      (wr_sel),
        .wr_pos      (wr_pos),
        .wr_data     (wr_data),
        .done        (done),
        .ready_next  (ready_next)
    );

    // Sentence memory. A read and a write never come from the same
    // transaction, and a write is visible to a read in the next cycle.
    // The read data register loads only on an accepted read, so it holds
    // steady while the result is stalled.
    nmea_filt_store #(
        .BUF_BYTES (BUF_BYTES),
        .WP_W      (WP_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_sel  (wr_sel),
        .wr_pos  (wr_pos),
        .wr_data (wr_data),
        .rd_en   (read_en && read_hit),
        .rd_sel  (buffer_select),
        .rd_pos  (read_position),
        .rd_data (mem_q)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_hit_reg   <= read_en && read_hit;
            ready_mask_reg <= ready_next;
            done_reg       <= done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_hit_reg ? mem_q : '0;
    assign ready_mask    = ready_mask_reg;
    assign sentence_done = done_reg.done;
    assign done_type     = done_reg.dtype;
    assign stored_length = done_reg.length;

endmodule
